// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of clk outside of reset.
`define PCBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked at every rising edge of clk, also while rst is high.
`define PCBD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// ----- hw/rtl/pcbd_pkg.sv -----
// Types, constants and blend functions of the column blend drawer.
package pcbd_pkg;

  localparam int TEXEL_DEPTH     = 256;
  localparam int TEXEL_AW        = $clog2(TEXEL_DEPTH);
  localparam int RGB_TABLE_DEPTH = 32768;
  localparam int RGB_AW          = $clog2(RGB_TABLE_DEPTH);
  localparam int PAL_DEPTH       = 256;
  localparam int PAL_AW          = 8;
  localparam int FRAC_BITS       = 16;
  localparam int ACC_W           = 24;
  localparam int PHASE_W         = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);
  localparam int CFG_IDX_W       = 8;

  localparam logic [ACC_W-1:0] ROW_STEP_RESET = 24'h010000;
  localparam logic [31:0] TL_FILL   = 32'h01f07c1f;
  localparam logic [31:0] ADD_GUARD = 32'h40100400;
  localparam logic [31:0] ADD_KEEP  = 32'h3fffffff;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STEP   = 8'd1;

  typedef enum logic [2:0] {
    REQ_PIXEL    = 3'd0,
    REQ_TEXEL_WR = 3'd1,
    REQ_TRANS_WR = 3'd2,
    REQ_FG_WR    = 3'd3,
    REQ_BG_WR    = 3'd4,
    REQ_RGB_WR   = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    MODE_PLAIN    = 3'd0,
    MODE_XLAT     = 3'd1,
    MODE_TL       = 3'd2,
    MODE_XLAT_TL  = 3'd3,
    MODE_ADD      = 3'd4,
    MODE_XLAT_ADD = 3'd5
  } blend_mode_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    req_t                req;
    logic [TEXEL_AW-1:0] texel_idx;
    logic [RGB_AW-1:0]   table_index;
    logic [31:0]         write_value;
    logic [7:0]          dest_pixel;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Unused mode codes draw as plain.
  function automatic blend_mode_t norm_mode(input logic [2:0] m);
    blend_mode_t r;
    case (m)
      MODE_XLAT:     r = MODE_XLAT;
      MODE_TL:       r = MODE_TL;
      MODE_XLAT_TL:  r = MODE_XLAT_TL;
      MODE_ADD:      r = MODE_ADD;
      MODE_XLAT_ADD: r = MODE_XLAT_ADD;
      default:       r = MODE_PLAIN;
    endcase
    return r;
  endfunction

  function automatic logic mode_translates(input blend_mode_t m);
    return (m == MODE_XLAT) || (m == MODE_XLAT_TL) || (m == MODE_XLAT_ADD);
  endfunction

  function automatic logic mode_is_plain(input blend_mode_t m);
    return (m == MODE_PLAIN) || (m == MODE_XLAT);
  endfunction

  // Blends the packed fg and bg words and folds the result to an RGB table index.
  function automatic logic [RGB_AW-1:0] rgb_index(input logic [31:0] fg,
                                                  input logic [31:0] bg,
                                                  input blend_mode_t m);
    logic [31:0] sum;
    logic [31:0] guard;
    logic [31:0] x;
    sum   = fg + bg;
    guard = sum & ADD_GUARD;
    guard = guard - (guard >> 5);
    if ((m == MODE_TL) || (m == MODE_XLAT_TL)) begin
      x = sum | TL_FILL;
    end else begin
      x = ((sum | TL_FILL) & ADD_KEEP) | guard;
    end
    return RGB_AW'(x & (x >> 15));
  endfunction

endpackage

// ----- hw/rtl/pcbd_if.sv -----
// Handshake channels of the column blend drawer: request, result and configuration.
interface pcbd_req_if import pcbd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [14:0] table_index;
  logic [31:0] write_value;
  logic [7:0]  dest_pixel;
  logic        column_start;
  logic [23:0] start_frac;
  logic [11:0] start_row;

  modport source (output valid, req_type, table_index, write_value, dest_pixel,
                  column_start, start_frac, start_row, input ready);
  modport sink (input valid, req_type, table_index, write_value, dest_pixel,
                column_start, start_frac, start_row, output ready);
endinterface

interface pcbd_rsp_if import pcbd_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink (input valid, pixel_out, output ready);
endinterface

interface pcbd_cfg_if import pcbd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/pcbd_queue.sv -----
// Short in-order queue between the front and the back of the drawer.
module pcbd_queue import pcbd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  entry_t        push_entry,
  input  logic          pop,
  output entry_t        head,
  output queue_status_t status
);

  entry_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

// ----- hw/rtl/pcbd_front.sv -----
// Front of the drawer: configuration registers, item intake, texel accumulator.
module pcbd_front import pcbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  pcbd_req_if.sink    req,
  pcbd_cfg_if.sink    cfg,
  input  logic        full,
  output logic        push,
  output entry_t      push_entry,
  output blend_mode_t mode
);

  logic [2:0]       blend_mode;
  logic [ACC_W-1:0] row_step;
  logic [ACC_W-1:0] frac_acc;
  logic [ACC_W-1:0] frac_acc_next;
  logic [27:0]      phase_prod;
  logic [ACC_W-1:0] seed;
  logic [ACC_W-1:0] cur_frac;
  logic             accept;
  logic             known;
  logic             is_pixel;

  assign cfg.ready = 1'b1;
  assign req.ready = !full;
  assign accept    = req.valid && req.ready;
  assign mode      = norm_mode(blend_mode);

  // Column seed: start fraction plus the sub-texel phase of the start row.
  always_comb begin
    phase_prod    = 28'(req.start_row) * 28'(row_step[PHASE_W-1:0]);
    seed          = req.start_frac + ACC_W'(phase_prod[PHASE_W-1:0]);
    cur_frac      = req.column_start ? seed : frac_acc;
    frac_acc_next = cur_frac + row_step;
  end

  // Classify the request; unused request codes are dropped here.
  always_comb begin
    known    = 1'b0;
    is_pixel = 1'b0;
    case (req.req_type)
      REQ_PIXEL: begin
        known    = 1'b1;
        is_pixel = 1'b1;
      end
      REQ_TEXEL_WR, REQ_TRANS_WR, REQ_FG_WR, REQ_BG_WR, REQ_RGB_WR: begin
        known = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  always_comb begin
    push                   = accept && known;
    push_entry.req         = req_t'(req.req_type);
    push_entry.texel_idx   = is_pixel ? TEXEL_AW'(cur_frac >> FRAC_BITS)
                                      : TEXEL_AW'(req.table_index);
    push_entry.table_index = req.table_index;
    push_entry.write_value = req.write_value;
    push_entry.dest_pixel  = req.dest_pixel;
  end

  // Configuration and accumulator registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= MODE_PLAIN;
      row_step   <= ROW_STEP_RESET;
      frac_acc   <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BLEND_MODE: blend_mode <= cfg.data[2:0];
          REG_ROW_STEP:   row_step   <= cfg.data[ACC_W-1:0];
          default:        ;
        endcase
      end
      if (accept && is_pixel) begin
        frac_acc <= frac_acc_next;
      end
    end
  end

endmodule

// ----- hw/rtl/pcbd_back.sv -----
// Back of the drawer: table stages that read and write in item order, then blend.
module pcbd_back import pcbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  entry_t      head,
  input  logic        empty,
  output logic        pop,
  input  blend_mode_t mode,
  pcbd_rsp_if.source  rsp
);

  logic [7:0]  texel_mem [TEXEL_DEPTH];
  logic [7:0]  trans_mem [PAL_DEPTH];
  logic [31:0] fg_mem    [PAL_DEPTH];
  logic [31:0] bg_mem    [PAL_DEPTH];
  logic [7:0]  rgb_mem   [RGB_TABLE_DEPTH];

  logic              adv;
  logic              v_b, v_c, v_d, v_e, v_f;
  entry_t            ent_b, ent_c, ent_d, ent_e;
  req_t              req_f;
  logic [7:0]        tex_b, tex_c, tex_d, tex_e, tex_f;
  logic [7:0]        tr_c;
  logic [7:0]        tex_sel_c;
  logic [31:0]       fg_d, bg_d;
  logic [RGB_AW-1:0] idx_e;
  logic [7:0]        rgb_f;
  logic              out_valid;
  logic [7:0]        pixel_out;

  // The whole pipe moves whenever the output register is free or being taken.
  assign adv           = !out_valid || rsp.ready;
  assign pop           = adv && !empty;
  assign rsp.valid     = out_valid;
  assign rsp.pixel_out = pixel_out;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      v_e       <= 1'b0;
      v_f       <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v_b       <= !empty;
      v_c       <= v_b;
      v_d       <= v_c;
      v_e       <= v_d;
      v_f       <= v_e;
      out_valid <= v_f && (req_f == REQ_PIXEL);
    end
  end

  // Texel store: sample at the accumulator's integer part.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (!empty && (head.req == REQ_TEXEL_WR)) begin
        texel_mem[head.texel_idx] <= head.write_value[7:0];
      end
      tex_b <= texel_mem[head.texel_idx];
      ent_b <= head;
    end
  end

  // Translation table.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v_b && (ent_b.req == REQ_TRANS_WR)) begin
        trans_mem[ent_b.table_index[PAL_AW-1:0]] <= ent_b.write_value[7:0];
      end
      tr_c  <= trans_mem[tex_b];
      tex_c <= tex_b;
      ent_c <= ent_b;
    end
  end

  assign tex_sel_c = mode_translates(mode) ? tr_c : tex_c;

  // Foreground and background packed-RGB tables.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v_c && (ent_c.req == REQ_FG_WR)) begin
        fg_mem[ent_c.table_index[PAL_AW-1:0]] <= ent_c.write_value;
      end
      if (v_c && (ent_c.req == REQ_BG_WR)) begin
        bg_mem[ent_c.table_index[PAL_AW-1:0]] <= ent_c.write_value;
      end
      fg_d  <= fg_mem[tex_sel_c];
      bg_d  <= bg_mem[ent_c.dest_pixel];
      tex_d <= tex_sel_c;
      ent_d <= ent_c;
    end
  end

  // Blend the packed words into an RGB table index.
  always_ff @(posedge clk) begin
    if (adv) begin
      idx_e <= rgb_index(fg_d, bg_d, mode);
      tex_e <= tex_d;
      ent_e <= ent_d;
    end
  end

  // RGB-to-palette table.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (v_e && (ent_e.req == REQ_RGB_WR)) begin
        rgb_mem[ent_e.table_index] <= ent_e.write_value[7:0];
      end
      rgb_f <= rgb_mem[idx_e];
      tex_f <= tex_e;
      req_f <= ent_e.req;
    end
  end

  // Output register: plain modes return the texel, others the palette byte.
  always_ff @(posedge clk) begin
    if (adv) begin
      pixel_out <= mode_is_plain(mode) ? tex_f : rgb_f;
    end
  end

endmodule

// ----- hw/rtl/patch_column_blend_drawer_unit.sv -----
// Top level of the column blend drawer: front, queue and back joined together.
//
// Channels: req takes one beat per item (a pixel or a table load), rsp gives
// one beat per pixel with the new framebuffer byte, and cfg writes blend_mode
// (index 0) and row_step (index 1) and is always ready. Loads give no beat.
// A pixel beat with column_start set reseeds the 8.16 texel accumulator
// before it samples; every pixel then advances it by row_step.
// A pixel passes from the queue through back stages b to f and the output register.
// Throughput: one item per cycle unless rsp stalls; each table sits in its own
// stage with one read or write per cycle, so a load and a pixel cost the same.
// Reset clears the accumulator, the configuration (blend_mode plain,
// row_step 1.0), the queue and all stage valid bits; table contents are
// undefined until loaded.
// When rsp is stalled the back holds; the four-entry queue keeps taking
// items until it fills, then req.ready drops.
module patch_column_blend_drawer_unit import pcbd_pkg::*; (
  input logic        clk,
  input logic        rst,
  pcbd_req_if.sink   req,
  pcbd_rsp_if.source rsp,
  pcbd_cfg_if.sink   cfg
);

  logic          push;
  entry_t        push_entry;
  logic          pop;
  entry_t        head;
  queue_status_t status;
  blend_mode_t   mode;

  pcbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg        (cfg),
    .full       (status.full),
    .push       (push),
    .push_entry (push_entry),
    .mode       (mode)
  );

  pcbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  pcbd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (status.empty),
    .pop   (pop),
    .mode  (mode),
    .rsp   (rsp)
  );

endmodule

// ----- hw/rtl/pcbd_checker.sv -----
// Port-level checker of the column blend drawer and its bind to the top level.
`include "assert_macros.svh"

module pcbd_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_pixel_out,
  input logic       cfg_ready
);

  // A stalled result beat stays up.
  `PCBD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped")

  // A stalled result beat keeps its byte.
  `PCBD_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_pixel_out), "rsp data moved")

  // After reset the pipe is empty and the queue takes items.
  `PCBD_ASSERT_RST(a_reset_idle, rst |=> !rsp_valid && req_ready ##1 !rsp_valid, "not idle after reset")

  // Configuration writes are never refused.
  `PCBD_ASSERT(a_cfg_ready, cfg_ready, "cfg refused")

endmodule

bind patch_column_blend_drawer_unit pcbd_checker u_pcbd_checker (
  .clk           (clk),
  .rst           (rst),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_pixel_out (rsp.pixel_out),
  .cfg_ready     (cfg.ready)
);

// ----- tb/sv/tb_patch_column_blend_drawer_unit.sv -----
// Self-checking testbench for the column blend drawer with its own blend predictor.
module tb_patch_column_blend_drawer_unit;
  import pcbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed.
  localparam logic [2:0] REQ_UNUSED_A  = 3'd6;
  localparam logic [2:0] REQ_UNUSED_B  = 3'd7;
  localparam logic [2:0] MODE_UNUSED_B = 3'd7;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int PHASES        = 10;
  // Pixels also pull in loads for the entries they read, roughly one per draw.
  localparam int PHASE_DRAWS   = 45;

  typedef struct {
    logic [2:0]  kind;
    logic [14:0] table_index;
    logic [31:0] write_value;
    logic [7:0]  dest_pixel;
    logic        column_start;
    logic [23:0] start_frac;
    logic [11:0] start_row;
  } draw_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  int   stall_left = 0;
  bit   src_gaps = 1'b1;
  bit   sink_stalls = 1'b1;
  int   error_count = 0;

  pcbd_req_if req();
  pcbd_rsp_if rsp();
  pcbd_cfg_if cfg();

  patch_column_blend_drawer_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always #2 clk = ~clk;

  assign rsp.ready = sink_ready;

  // Predicted drawer state: registers, accumulator and the loaded tables.
  logic [2:0]       mode_reg = MODE_PLAIN;
  logic [ACC_W-1:0] step_reg = ROW_STEP_RESET;
  logic [ACC_W-1:0] acc = '0;
  logic [7:0]       texels [TEXEL_DEPTH];
  logic [7:0]       xlat_map [PAL_DEPTH];
  logic [31:0]      fg_words [PAL_DEPTH];
  logic [31:0]      bg_words [PAL_DEPTH];
  logic [7:0]       palette_of_rgb [RGB_TABLE_DEPTH];
  bit               texel_set [TEXEL_DEPTH];
  bit               xlat_set [PAL_DEPTH];
  bit               fg_set [PAL_DEPTH];
  bit               bg_set [PAL_DEPTH];
  bit               rgb_set [RGB_TABLE_DEPTH];
  logic [7:0]       pending_pixels [$];

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic blend_mode_t active_mode();
    return (mode_reg > 3'(MODE_XLAT_ADD)) ? MODE_PLAIN : blend_mode_t'(mode_reg);
  endfunction

  // Accumulator value that a pixel samples with, after any column reseed.
  function automatic logic [ACC_W-1:0] start_acc(input draw_item_t it);
    logic [35:0] prod;
    if (!it.column_start) return acc;
    prod = it.start_row * step_reg;
    return it.start_frac + ACC_W'(prod[PHASE_W-1:0]);
  endfunction

  function automatic int texel_slot(input logic [ACC_W-1:0] a);
    return int'(a[ACC_W-1:FRAC_BITS]) % TEXEL_DEPTH;
  endfunction

  // Packed RGB sum, optional channel saturation, then fold to a 15-bit index.
  function automatic logic [RGB_AW-1:0] blend_slot(input logic [7:0] tex,
                                                   input logic [7:0] dest,
                                                   input bit add_mode);
    logic [31:0] s;
    logic [31:0] g;
    logic [31:0] x;
    s = fg_words[tex] + bg_words[dest];
    x = s | TL_FILL;
    if (add_mode) begin
      g = s & ADD_GUARD;
      g = g - (g >> 5);
      x = (x & ADD_KEEP) | g;
    end
    return RGB_AW'(x & (x >> 15));
  endfunction

  function automatic logic [7:0] drawn_byte(input logic [ACC_W-1:0] a, input logic [7:0] dest);
    blend_mode_t m;
    logic [7:0]  tex;
    m = active_mode();
    tex = texels[texel_slot(a)];
    if (m inside {MODE_XLAT, MODE_XLAT_TL, MODE_XLAT_ADD}) tex = xlat_map[tex];
    if (m inside {MODE_PLAIN, MODE_XLAT}) return tex;
    return palette_of_rgb[blend_slot(tex, dest, m inside {MODE_ADD, MODE_XLAT_ADD})];
  endfunction

  // Applies one accepted beat to the predicted state.
  function automatic void advance_drawer(input draw_item_t it);
    int ti;
    int pi;
    ti = int'(it.table_index) % TEXEL_DEPTH;
    pi = int'(it.table_index[7:0]);
    case (it.kind)
      REQ_PIXEL: begin
        acc = start_acc(it);
        pending_pixels.push_back(drawn_byte(acc, it.dest_pixel));
        acc = acc + step_reg;
      end
      REQ_TEXEL_WR: begin
        texels[ti] = it.write_value[7:0];
        texel_set[ti] = 1'b1;
      end
      REQ_TRANS_WR: begin
        xlat_map[pi] = it.write_value[7:0];
        xlat_set[pi] = 1'b1;
      end
      REQ_FG_WR: begin
        fg_words[pi] = it.write_value;
        fg_set[pi] = 1'b1;
      end
      REQ_BG_WR: begin
        bg_words[pi] = it.write_value;
        bg_set[pi] = 1'b1;
      end
      REQ_RGB_WR: begin
        palette_of_rgb[it.table_index] = it.write_value[7:0];
        rgb_set[it.table_index] = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic draw_item_t random_item(input logic [2:0] kind);
    draw_item_t it;
    it.kind = kind;
    it.table_index = 15'($urandom);
    it.write_value = $urandom;
    it.dest_pixel = 8'($urandom);
    it.column_start = 1'($urandom);
    it.start_frac = 24'($urandom);
    it.start_row = 12'($urandom);
    return it;
  endfunction

  // A load that lands on entry idx of a table with span entries.
  function automatic draw_item_t load_item(input logic [2:0] kind, input int idx, input int span);
    draw_item_t it;
    it = random_item(kind);
    it.table_index = 15'(idx + span * $urandom_range(0, RGB_TABLE_DEPTH / span - 1));
    return it;
  endfunction

  function automatic draw_item_t load_at(input logic [2:0] kind, input logic [14:0] idx,
                                         input logic [31:0] value);
    draw_item_t it;
    it = random_item(kind);
    it.table_index = idx;
    it.write_value = value;
    return it;
  endfunction

  function automatic draw_item_t pixel_item(input logic cs, input logic [23:0] frac,
                                            input logic [11:0] row, input logic [7:0] dest);
    draw_item_t it;
    it = random_item(REQ_PIXEL);
    it.column_start = cs;
    it.start_frac = frac;
    it.start_row = row;
    it.dest_pixel = dest;
    return it;
  endfunction

  // Sends one request beat after an optional gap and predicts its effect.
  task automatic send_item(input draw_item_t it);
    int gap;
    gap = src_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= it.kind;
    req.table_index <= it.table_index;
    req.write_value <= it.write_value;
    req.dest_pixel <= it.dest_pixel;
    req.column_start <= it.column_start;
    req.start_frac <= it.start_frac;
    req.start_row <= it.start_row;
    do @(posedge clk); while (!req.ready);
    advance_drawer(it);
  endtask

  // Loads every table entry the pixel will read that was never written, then sends it.
  task automatic send_pixel(input draw_item_t it);
    blend_mode_t      m;
    int               ti;
    logic [7:0]       tex;
    logic [RGB_AW-1:0] slot;
    m = active_mode();
    ti = texel_slot(start_acc(it));
    if (!texel_set[ti]) send_item(load_item(REQ_TEXEL_WR, ti, TEXEL_DEPTH));
    tex = texels[ti];
    if (m inside {MODE_XLAT, MODE_XLAT_TL, MODE_XLAT_ADD}) begin
      if (!xlat_set[tex]) send_item(load_item(REQ_TRANS_WR, tex, PAL_DEPTH));
      tex = xlat_map[tex];
    end
    if (!(m inside {MODE_PLAIN, MODE_XLAT})) begin
      if (!fg_set[tex]) send_item(load_item(REQ_FG_WR, tex, PAL_DEPTH));
      if (!bg_set[it.dest_pixel]) send_item(load_item(REQ_BG_WR, it.dest_pixel, PAL_DEPTH));
      slot = blend_slot(tex, it.dest_pixel, m inside {MODE_ADD, MODE_XLAT_ADD});
      if (!rgb_set[slot]) send_item(load_item(REQ_RGB_WR, slot, RGB_TABLE_DEPTH));
    end
    it.kind = REQ_PIXEL;
    send_item(it);
  endtask

  // Holds the sender until every predicted pixel has come out.
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_BLEND_MODE) mode_reg = data[2:0];
    else if (idx == REG_ROW_STEP) step_reg = data[ACC_W-1:0];
  endtask

  // Table loads at the index extremes and unused request codes that carry a column start.
  task automatic test_loads_and_unused_requests();
    draw_item_t it;
    send_item(load_at(REQ_TEXEL_WR, 15'h7fff, 32'hffffffff));
    send_item(load_at(REQ_TEXEL_WR, 15'h0000, 32'h00000000));
    send_item(load_at(REQ_TRANS_WR, 15'h7fff, 32'hffffff00));
    send_item(load_at(REQ_TRANS_WR, 15'h7f00, 32'h000000ff));
    send_item(load_at(REQ_FG_WR, 15'h7f00, 32'hffffffff));
    send_item(load_at(REQ_BG_WR, 15'h00ff, 32'h00000000));
    send_item(load_at(REQ_RGB_WR, 15'h7fff, 32'hffffffff));
    it = random_item(REQ_UNUSED_A);
    it.column_start = 1'b1;
    send_item(it);
    it = random_item(REQ_UNUSED_B);
    it.column_start = 1'b1;
    send_item(it);
    send_pixel(pixel_item(1'b0, 24'h000000, 12'h000, 8'h00));
  endtask

  // Column seeds at the fraction extremes and the accumulator wrapping past the top.
  task automatic test_column_seed_and_wrap();
    send_pixel(pixel_item(1'b1, 24'hff0000, 12'h000, 8'hff));
    send_pixel(pixel_item(1'b0, 24'h000000, 12'h000, 8'h00));
    send_pixel(pixel_item(1'b1, 24'hffffff, 12'hfff, 8'hff));
    send_pixel(pixel_item(1'b0, 24'h000000, 12'h000, 8'h00));
  endtask

  // One pixel in each mode code, the two unused ones included.
  task automatic test_blend_modes();
    for (int m = int'(MODE_PLAIN); m <= int'(MODE_UNUSED_B); m++) begin
      write_register(REG_BLEND_MODE, 32'(m));
      send_pixel(pixel_item(1'b1, 24'(m) << FRAC_BITS, 12'h000, (m % 2) ? 8'hff : 8'h00));
    end
  endtask

  // Zero and full-scale steps, with the start row phase at its largest.
  task automatic test_step_extremes();
    write_register(REG_ROW_STEP, 32'h0);
    send_pixel(pixel_item(1'b1, 24'h7fffff, 12'hfff, 8'h5a));
    send_pixel(pixel_item(1'b0, 24'h000000, 12'h000, 8'ha5));
    write_register(REG_ROW_STEP, 32'h00ffffff);
    send_pixel(pixel_item(1'b1, 24'hffffff, 12'hfff, 8'hff));
    send_pixel(pixel_item(1'b0, 24'h000000, 12'h000, 8'h00));
  endtask

  // Register writes with stray high bits and a write to an index that holds nothing.
  task automatic test_register_masking();
    write_register(REG_BLEND_MODE, 32'hfffffffc);
    write_register(REG_ROW_STEP, 32'hff018000);
    write_register(REG_NONE, 32'hffffffff);
    send_pixel(pixel_item(1'b1, 24'h123456, 12'h801, 8'h80));
    send_pixel(pixel_item(1'b0, 24'h000000, 12'h000, 8'h7f));
  endtask

  // Random phases, each under its own register setting and idling pattern.
  task automatic test_random_stream();
    draw_item_t  it;
    int          r;
    logic [2:0]  mode;
    logic [23:0] step;
    for (int p = 0; p < PHASES; p++) begin
      mode = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0: step = 24'h000000;
        1: step = 24'hffffff;
        2: step = ROW_STEP_RESET;
        3: step = 24'($urandom_range(0, 24'h03ffff));
        4: step = 24'($urandom_range(1, 24'hffffff));
        default: step = 24'h000001;
      endcase
      write_register(REG_BLEND_MODE, ($urandom & ~32'h7) | 32'(mode));
      write_register(REG_ROW_STEP, {8'($urandom), step});
      src_gaps = !(p == 3 || p == 6);
      sink_stalls = !(p == 3 || p == 7);
      for (int d = 0; d < PHASE_DRAWS; d++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          it = random_item(REQ_PIXEL);
          it.column_start = ($urandom_range(0, 7) == 0);
          send_pixel(it);
        end else if (r < 95) begin
          send_item(random_item(3'($urandom_range(int'(REQ_TEXEL_WR), int'(REQ_RGB_WR)))));
        end else begin
          send_item(random_item(3'($urandom_range(int'(REQ_UNUSED_A), int'(REQ_UNUSED_B)))));
        end
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
    end
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // Receiver stalls: runs of ready with random stalls of mostly short length.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
      stall_left <= pick_gap();
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Compare every result beat with the oldest predicted pixel.
  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel_out expected none actual %02h", rsp.pixel_out);
        error_count++;
      end else begin
        if (rsp.pixel_out !== pending_pixels[0]) begin
          $error("pixel_out expected %02h actual %02h", pending_pixels[0], rsp.pixel_out);
          error_count++;
        end
        void'(pending_pixels.pop_front());
      end
    end
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    req.valid <= 1'b0;
    req.req_type <= REQ_PIXEL;
    req.table_index <= '0;
    req.write_value <= '0;
    req.dest_pixel <= '0;
    req.column_start <= 1'b0;
    req.start_frac <= '0;
    req.start_row <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_BLEND_MODE;
    cfg.data <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_loads_and_unused_requests();
    test_column_seed_and_wrap();
    test_blend_modes();
    test_step_extremes();
    test_register_masking();
    test_random_stream();

    // Drain what is still in flight, then give the pipeline time to go quiet.
    req.valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && pending_pixels.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pixels.size() != 0) begin
      $error("pixel_out expected %02h actual none (%0d beats missing)",
             pending_pixels[0], pending_pixels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
